// ===== sv/rhc_pkg.sv =====
package rhc_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 4;
    localparam int CMAX              = (1 << CHANNEL_BITS) - 1;
    localparam int HUE_SIXTY         = 60 << HUE_FRACTION_BITS;
    localparam int HUE_FULL          = 6 * HUE_SIXTY;
    localparam int HSV_DEN           = CMAX * HUE_SIXTY;

    localparam int FIRST_W = 13;
    localparam int NUM_W   = 27;
    localparam int DEN_W   = 19;
    localparam int Q_W     = 13;
    localparam int TOT_W   = 25;

    localparam logic [2:0] SEL_RED   = 3'd0;
    localparam logic [2:0] SEL_GREEN = 3'd1;
    localparam logic [2:0] SEL_BLUE  = 3'd2;

    localparam logic CMD_RGB2HSV = 1'b0;
    localparam logic CMD_HSV2RGB = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [FIRST_W-1:0]      in_first;
        logic [CHANNEL_BITS-1:0] in_second;
        logic [CHANNEL_BITS-1:0] in_third;
    } item_in_t;

    typedef struct packed {
        logic [FIRST_W-1:0]      out_first;
        logic [CHANNEL_BITS-1:0] out_second;
        logic [CHANNEL_BITS-1:0] out_third;
    } item_out_t;

    typedef struct packed {
        logic                    command;
        logic [2:0]              seg;
        logic [CHANNEL_BITS-1:0] val;
        logic                    hue_zero;
        logic                    sat_zero;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem_a;
        logic [NUM_W-1:0] rem_b;
        logic [DEN_W-1:0] den_a;
        logic [DEN_W-1:0] den_b;
        logic [Q_W-1:0]   q_a;
        logic [Q_W-1:0]   q_b;
        side_t            side;
    } div_t;

endpackage

// ===== sv/rhc_prep.sv =====
module rhc_prep
    import rhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid_in,
    input  item_in_t data_in,
    output logic     valid_out,
    output div_t     data_out
);

    typedef struct packed {
        logic                    command;
        logic [2:0]              sel;
        logic [CHANNEL_BITS-1:0] r;
        logic [CHANNEL_BITS-1:0] g;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] mx;
        logic [CHANNEL_BITS-1:0] d;
        logic [2:0]              seg;
        logic [9:0]              t;
        logic [15:0]             vs;
        logic [15:0]             vn;
    } p1_t;

    p1_t  p1_reg, p1_next;
    logic v1_reg;
    div_t out_reg, out_next;
    logic v2_reg;

    logic [CHANNEL_BITS-1:0] r, g, b, v, s, mx, mn;
    logic [FIRST_W-1:0]      h, rem;

    always_comb
    begin
        r = (data_in.in_first > FIRST_W'(CMAX)) ? CHANNEL_BITS'(CMAX)
                                                : data_in.in_first[CHANNEL_BITS-1:0];
        g = data_in.in_second;
        b = data_in.in_third;
        s = data_in.in_second;
        v = data_in.in_third;
        p1_next = '0;
        p1_next.command = data_in.command;
        p1_next.r = r;
        p1_next.g = g;
        p1_next.b = b;
        if (r >= g && r >= b)
        begin
            p1_next.sel = SEL_RED;
            mx = r;
        end
        else if (g >= b)
        begin
            p1_next.sel = SEL_GREEN;
            mx = g;
        end
        else
        begin
            p1_next.sel = SEL_BLUE;
            mx = b;
        end
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        p1_next.mx = mx;
        p1_next.d  = mx - mn;

        h = (data_in.in_first >= FIRST_W'(HUE_FULL))
            ? data_in.in_first - FIRST_W'(HUE_FULL) : data_in.in_first;
        if (h >= FIRST_W'(5 * HUE_SIXTY))
        begin
            p1_next.seg = 3'd5;
            rem = h - FIRST_W'(5 * HUE_SIXTY);
        end
        else if (h >= FIRST_W'(4 * HUE_SIXTY))
        begin
            p1_next.seg = 3'd4;
            rem = h - FIRST_W'(4 * HUE_SIXTY);
        end
        else if (h >= FIRST_W'(3 * HUE_SIXTY))
        begin
            p1_next.seg = 3'd3;
            rem = h - FIRST_W'(3 * HUE_SIXTY);
        end
        else if (h >= FIRST_W'(2 * HUE_SIXTY))
        begin
            p1_next.seg = 3'd2;
            rem = h - FIRST_W'(2 * HUE_SIXTY);
        end
        else if (h >= FIRST_W'(HUE_SIXTY))
        begin
            p1_next.seg = 3'd1;
            rem = h - FIRST_W'(HUE_SIXTY);
        end
        else
        begin
            p1_next.seg = 3'd0;
            rem = h;
        end
        p1_next.t  = p1_next.seg[0] ? 10'(FIRST_W'(HUE_SIXTY) - rem) : rem[9:0];
        p1_next.vs = 16'(v) * 16'(s);
        p1_next.vn = 16'(v) * 16'(CHANNEL_BITS'(CMAX) - s);
        if (data_in.command == CMD_HSV2RGB)
            p1_next.mx = v;
    end

    logic [TOT_W-1:0] tot;
    logic [NUM_W-1:0] xs, ms;

    always_comb
    begin
        out_next = '0;
        out_next.side.command = p1_reg.command;
        out_next.side.seg     = p1_reg.seg;
        out_next.side.val     = p1_reg.mx;
        tot = '0;
        xs  = '0;
        ms  = '0;
        if (p1_reg.command == CMD_RGB2HSV)
        begin
            case (p1_reg.sel)
                SEL_RED:
                begin
                    if (p1_reg.g >= p1_reg.b)
                        tot = TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.g - p1_reg.b);
                    else
                        tot = TOT_W'(HUE_FULL) * TOT_W'(p1_reg.d)
                            - TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.b - p1_reg.g);
                end
                SEL_GREEN:
                    tot = TOT_W'(2 * HUE_SIXTY) * TOT_W'(p1_reg.d)
                        + TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.b)
                        - TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.r);
                default:
                    tot = TOT_W'(4 * HUE_SIXTY) * TOT_W'(p1_reg.d)
                        + TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.r)
                        - TOT_W'(HUE_SIXTY) * TOT_W'(p1_reg.g);
            endcase
            out_next.rem_a = (NUM_W'(tot) << 1) + NUM_W'(p1_reg.d);
            out_next.den_a = DEN_W'(p1_reg.d) << 1;
            out_next.rem_b = NUM_W'(2 * CMAX) * NUM_W'(p1_reg.d) + NUM_W'(p1_reg.mx);
            out_next.den_b = DEN_W'(p1_reg.mx) << 1;
            out_next.side.hue_zero = (p1_reg.d == '0);
            out_next.side.sat_zero = (p1_reg.mx == '0);
        end
        else
        begin
            xs = NUM_W'(p1_reg.vs) * NUM_W'(p1_reg.t);
            ms = NUM_W'(p1_reg.vn) * NUM_W'(HUE_SIXTY);
            out_next.rem_a = ((xs + ms) << 1) + NUM_W'(HSV_DEN);
            out_next.den_a = DEN_W'(2 * HSV_DEN);
            out_next.rem_b = (NUM_W'(p1_reg.vn) << 1) + NUM_W'(CMAX);
            out_next.den_b = DEN_W'(2 * CMAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= p1_next;
        out_reg <= out_next;
    end

    assign valid_out = v2_reg;
    assign data_out  = out_reg;

endmodule

// ===== sv/rhc_div_cell.sv =====
module rhc_div_cell
    import rhc_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic valid_in,
    input  div_t data_in,
    output logic valid_out,
    output div_t data_out
);

    localparam int WIDE_W = DEN_W + Q_W;

    div_t data_next, data_reg;
    logic valid_reg;
    logic [WIDE_W-1:0] trial_a, trial_b;

    always_comb
    begin
        data_next = data_in;
        trial_a = WIDE_W'(data_in.den_a) << SHIFT;
        trial_b = WIDE_W'(data_in.den_b) << SHIFT;
        if (WIDE_W'(data_in.rem_a) >= trial_a)
        begin
            data_next.rem_a = data_in.rem_a - trial_a[NUM_W-1:0];
            data_next.q_a   = {data_in.q_a[Q_W-2:0], 1'b1};
        end
        else
            data_next.q_a   = {data_in.q_a[Q_W-2:0], 1'b0};
        if (WIDE_W'(data_in.rem_b) >= trial_b)
        begin
            data_next.rem_b = data_in.rem_b - trial_b[NUM_W-1:0];
            data_next.q_b   = {data_in.q_b[Q_W-2:0], 1'b1};
        end
        else
            data_next.q_b   = {data_in.q_b[Q_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== sv/rhc_post.sv =====
module rhc_post
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    input  div_t      data_in,
    output logic      valid_out,
    output item_out_t data_out
);

    item_out_t out_reg, out_next;
    logic      valid_reg;
    logic [CHANNEL_BITS-1:0] full, xv, zv;
    logic [Q_W-1:0] hue;

    always_comb
    begin
        out_next = '0;
        full = data_in.side.val;
        xv   = data_in.q_a[CHANNEL_BITS-1:0];
        zv   = data_in.q_b[CHANNEL_BITS-1:0];
        hue  = (data_in.q_a >= Q_W'(HUE_FULL)) ? data_in.q_a - Q_W'(HUE_FULL) : data_in.q_a;
        if (data_in.side.command == CMD_RGB2HSV)
        begin
            out_next.out_first  = data_in.side.hue_zero ? '0 : FIRST_W'(hue);
            out_next.out_second = data_in.side.sat_zero ? '0 : zv;
            out_next.out_third  = full;
        end
        else
        begin
            case (data_in.side.seg)
                3'd0:
                begin
                    out_next.out_first = FIRST_W'(full);
                    out_next.out_second = xv;
                    out_next.out_third = zv;
                end
                3'd1:
                begin
                    out_next.out_first = FIRST_W'(xv);
                    out_next.out_second = full;
                    out_next.out_third = zv;
                end
                3'd2:
                begin
                    out_next.out_first = FIRST_W'(zv);
                    out_next.out_second = full;
                    out_next.out_third = xv;
                end
                3'd3:
                begin
                    out_next.out_first = FIRST_W'(zv);
                    out_next.out_second = xv;
                    out_next.out_third = full;
                end
                3'd4:
                begin
                    out_next.out_first = FIRST_W'(xv);
                    out_next.out_second = zv;
                    out_next.out_third = full;
                end
                default:
                begin
                    out_next.out_first = FIRST_W'(full);
                    out_next.out_second = zv;
                    out_next.out_third = xv;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = out_reg;

endmodule

// ===== sv/rgb_hsv_color_converter.sv =====
// RGB <-> HSV pixel converter, one transaction per pixel.
// Input: a transaction is taken on a rising edge with start high and busy
// low. busy is always low, so a pixel may be issued on every clock.
// source.command selects RGB to HSV (0) or HSV to RGB (1).
// Output: done is high for exactly one cycle with the converted pixel on
// result; the receiver cannot stall, so results must be taken as shown.
// Between the accepting edge and the result sit two set-up stages (channel
// max/min, hue sector, then the products forming the numerators), a chain
// of 13 divider cells each settling one quotient bit for both divisions (hue
// and saturation, or the two channel values for HSV to RGB), and one output
// stage that wraps the hue and routes the channels.
// Throughput is one pixel per clock; the divider chain is fully pipelined.
// Reset clears only the valid flags through the chain, so nothing in
// flight is reported after reset; the data registers are not reset.
module rgb_hsv_color_converter
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  item_in_t  source,
    output logic      done,
    output item_out_t result
);

    logic           v_link [Q_W+1];
    div_t           d_link [Q_W+1];

    assign busy = 1'b0;

    rhc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .data_in   (source),
        .valid_out (v_link[0]),
        .data_out  (d_link[0])
    );

    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        rhc_div_cell #(
            .SHIFT (Q_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v_link[i]),
            .data_in   (d_link[i]),
            .valid_out (v_link[i+1]),
            .data_out  (d_link[i+1])
        );
    end

    rhc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v_link[Q_W]),
        .data_in   (d_link[Q_W]),
        .valid_out (done),
        .data_out  (result)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rhc_pkg::*;

    localparam int LATENCY    = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int IN_W       = $bits(item_in_t);

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    item_in_t  source;
    logic      done;
    item_out_t result;

    item_in_t  pixel_queue[$];
    item_out_t converted_queue[$];
    int        errors;
    int        idle_cycles;
    int        sender_idle_pct;

    rgb_hsv_color_converter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .source (source),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned div_round(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic item_out_t convert_pixel(item_in_t px);
        item_out_t      res;
        longint unsigned a, b, c, mx, mn, d, hue, sat, total;
        longint unsigned seg, rem, t, cs, xs, ms, full, xv, zv, rv, gv, bv;
        a   = px.in_first;
        b   = px.in_second;
        c   = px.in_third;
        hue = 0;
        sat = 0;
        if (px.command == CMD_RGB2HSV)
        begin
            if (a > CMAX)
                a = CMAX;
            mx = a;
            mn = a;
            if (b > mx) mx = b;
            if (c > mx) mx = c;
            if (b < mn) mn = b;
            if (c < mn) mn = c;
            d = mx - mn;
            if (d != 0)
            begin
                if (a == mx)
                    total = (b >= c) ? HUE_SIXTY * (b - c) : HUE_FULL * d - HUE_SIXTY * (c - b);
                else if (b == mx)
                    total = 2 * HUE_SIXTY * d + HUE_SIXTY * c - HUE_SIXTY * a;
                else
                    total = 4 * HUE_SIXTY * d + HUE_SIXTY * a - HUE_SIXTY * b;
                hue = div_round(total, d);
                if (hue >= HUE_FULL)
                    hue -= HUE_FULL;
            end
            if (mx != 0)
                sat = div_round(d * CMAX, mx);
            res.out_first  = hue[FIRST_W-1:0];
            res.out_second = sat[CHANNEL_BITS-1:0];
            res.out_third  = mx[CHANNEL_BITS-1:0];
        end
        else
        begin
            a    = a % HUE_FULL;
            seg  = a / HUE_SIXTY;
            rem  = a % HUE_SIXTY;
            t    = seg[0] ? HUE_SIXTY - rem : rem;
            cs   = c * b * HUE_SIXTY;
            xs   = c * b * t;
            ms   = c * HSV_DEN - cs;
            full = div_round(cs + ms, HSV_DEN);
            xv   = div_round(xs + ms, HSV_DEN);
            zv   = div_round(ms, HSV_DEN);
            case (seg)
                0:       begin rv = full; gv = xv;   bv = zv;   end
                1:       begin rv = xv;   gv = full; bv = zv;   end
                2:       begin rv = zv;   gv = full; bv = xv;   end
                3:       begin rv = zv;   gv = xv;   bv = full; end
                4:       begin rv = xv;   gv = zv;   bv = full; end
                default: begin rv = full; gv = zv;   bv = xv;   end
            endcase
            res.out_first  = rv[FIRST_W-1:0];
            res.out_second = gv[CHANNEL_BITS-1:0];
            res.out_third  = bv[CHANNEL_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic add_pixel(logic cmd, int first, int second, int third);
        item_in_t px;
        px.command   = cmd;
        px.in_first  = FIRST_W'(first);
        px.in_second = CHANNEL_BITS'(second);
        px.in_third  = CHANNEL_BITS'(third);
        pixel_queue.push_back(px);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            converted_queue.push_back(convert_pixel(source));
            void'(pixel_queue.pop_front());
        end
        if (rst_n && pixel_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct)
        begin
            start  <= 1'b1;
            source <= pixel_queue[0];
        end
        else
        begin
            start  <= 1'b0;
            source <= IN_W'($urandom);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (converted_queue.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                if (result.out_first != converted_queue[0].out_first)
                    report_mismatch("out_first", result.out_first, converted_queue[0].out_first);
                if (result.out_second != converted_queue[0].out_second)
                    report_mismatch("out_second", result.out_second, converted_queue[0].out_second);
                if (result.out_third != converted_queue[0].out_third)
                    report_mismatch("out_third", result.out_third, converted_queue[0].out_third);
                void'(converted_queue.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL rgb_hsv_color_converter");
            $finish;
        end
    end

    initial
    begin
        int i, k, r, g, b;
        errors          = 0;
        idle_cycles     = 0;
        sender_idle_pct = 18;
        rst_n           = 1'b0;
        start           = 1'b0;
        source          = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, grey, black, max ties, red over range, hue wrap
        add_pixel(CMD_RGB2HSV, 0, 0, 0);
        add_pixel(CMD_RGB2HSV, 255, 255, 255);
        add_pixel(CMD_RGB2HSV, 128, 128, 128);
        add_pixel(CMD_RGB2HSV, 255, 0, 0);
        add_pixel(CMD_RGB2HSV, 0, 255, 0);
        add_pixel(CMD_RGB2HSV, 0, 0, 255);
        add_pixel(CMD_RGB2HSV, 255, 255, 0);
        add_pixel(CMD_RGB2HSV, 0, 255, 255);
        add_pixel(CMD_RGB2HSV, 255, 0, 255);
        add_pixel(CMD_RGB2HSV, 255, 0, 1);
        add_pixel(CMD_RGB2HSV, 8191, 10, 20);
        add_pixel(CMD_RGB2HSV, 300, 255, 0);
        add_pixel(CMD_RGB2HSV, 255, 254, 255);
        add_pixel(CMD_HSV2RGB, 0, 0, 0);
        add_pixel(CMD_HSV2RGB, 0, 255, 255);
        add_pixel(CMD_HSV2RGB, HUE_FULL - 1, 255, 255);
        add_pixel(CMD_HSV2RGB, HUE_FULL, 255, 255);
        add_pixel(CMD_HSV2RGB, 8191, 255, 255);
        add_pixel(CMD_HSV2RGB, HUE_SIXTY, 128, 200);
        add_pixel(CMD_HSV2RGB, 2 * HUE_SIXTY + 7, 255, 100);
        add_pixel(CMD_HSV2RGB, 3 * HUE_SIXTY + 480, 60, 255);
        add_pixel(CMD_HSV2RGB, 4 * HUE_SIXTY + 1, 255, 1);
        add_pixel(CMD_HSV2RGB, 5 * HUE_SIXTY + 959, 200, 200);

        for (k = 0; k < 3; k++)
        begin
            sender_idle_pct = (k == 0) ? 18 : (k == 1) ? 60 : 0;
            for (i = 0; i < 650; i++)
            begin
                r = $urandom_range(255);
                g = $urandom_range(255);
                b = $urandom_range(255);
                case ($urandom_range(9))
                    0: add_pixel(1'($urandom_range(1)), $urandom_range(8191), g, b);
                    1: add_pixel(CMD_RGB2HSV, r, r, ($urandom_range(1)) ? r : b);
                    2: add_pixel(CMD_RGB2HSV, $urandom_range(8191, 256), g, b);
                    3, 4, 5: add_pixel(CMD_RGB2HSV, r, g, b);
                    default: add_pixel(CMD_HSV2RGB, $urandom_range(HUE_FULL - 1), g, b);
                endcase
            end
            while (pixel_queue.size() > 0)
                @(posedge clk);
        end

        while (converted_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && converted_queue.size() == 0)
            $display("PASS rgb_hsv_color_converter");
        else
            $display("FAIL rgb_hsv_color_converter");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/rhc_pkg.sv
sv/rhc_prep.sv
sv/rhc_div_cell.sv
sv/rhc_post.sv
sv/rgb_hsv_color_converter.sv
bench/tb.sv
